>>> src/assert_macros.svh
// assertion helpers shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, ignored while in reset
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, ignored while in reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication that also holds across reset
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> src/skf_pkg.sv
package skf_pkg;

  localparam int CHANNELS_DEF    = 6;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int CH_W       = 3;
  localparam int EST_W      = 16;
  localparam int GAIN_W     = 16;
  localparam int NOISE_W    = 16;
  localparam int NOISE_FRAC = 8;
  localparam int ACCEL_AXES = 3;

  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 4;

  localparam logic [NOISE_W-1:0] ACCEL_Q_RST = 16'd26;
  localparam logic [NOISE_W-1:0] ACCEL_R_RST = 16'd1920;
  localparam logic [NOISE_W-1:0] GYRO_Q_RST  = 16'd192;
  localparam logic [NOISE_W-1:0] GYRO_R_RST  = 16'd1280;

  typedef enum logic [1:0] {
    REG_ACCEL_Q = 2'd0,
    REG_ACCEL_R = 2'd1,
    REG_GYRO_Q  = 2'd2,
    REG_GYRO_R  = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_DIV_INIT,
    S_DIV,
    S_GAIN,
    S_MUL_X,
    S_X_UPD,
    S_MUL_P,
    S_DONE
  } skf_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic predict;
    logic div_init;
    logic div_step;
    logic gain_set;
    logic mul_step;
    logic x_update;
    logic commit;
  } skf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bad_ch;
    logic res_busy;
  } skf_stat_t;

endpackage

>>> src/skf_stream_if.sv
interface skf_in_if import skf_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [CH_W-1:0]               channel;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, channel, sample, input ready);
  modport sink   (input valid, channel, sample, output ready);
endinterface

interface skf_out_if import skf_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [CH_W-1:0]         channel_out;
  logic signed [EST_W-1:0] estimate;
  logic [GAIN_W-1:0]       gain;

  modport source (output valid, channel_out, estimate, gain, input ready);
  modport sink   (input valid, channel_out, estimate, gain, output ready);
endinterface

>>> src/skf_ctrl.sv
module skf_ctrl import skf_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  skf_stat_t stat,
  output skf_cmd_t  cmd
);

  localparam int QW = FRAC_BITS + 1;
  localparam int CW = $clog2(QW);
  localparam logic [CW-1:0] LAST = CW'(QW - 1);

  skf_state_t      state, state_next;
  logic [CW-1:0]   cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        // no transfer while in reset
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        if (stat.bad_ch) begin
          state_next = S_DONE;
        end else begin
          cmd.predict = 1'b1;
          state_next  = S_DIV_INIT;
        end
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == LAST) begin
          cnt_next   = '0;
          state_next = S_GAIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_GAIN: begin
        cmd.gain_set = 1'b1;
        state_next   = S_MUL_X;
      end
      S_MUL_X: begin
        cmd.mul_step = 1'b1;
        if (cnt == LAST) begin
          cnt_next   = '0;
          state_next = S_X_UPD;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_X_UPD: begin
        cmd.x_update = 1'b1;
        state_next   = S_MUL_P;
      end
      S_MUL_P: begin
        cmd.mul_step = 1'b1;
        if (cnt == LAST) begin
          cnt_next   = '0;
          state_next = S_DONE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_DONE: begin
        if (!stat.res_busy) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> src/skf_datapath.sv
module skf_datapath import skf_pkg::*; #(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  skf_cmd_t                      cmd,
  output skf_stat_t                     stat,
  input  logic [CH_W-1:0]               in_channel,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic [NOISE_W-1:0]            accel_q,
  input  logic [NOISE_W-1:0]            accel_r,
  input  logic [NOISE_W-1:0]            gyro_q,
  input  logic [NOISE_W-1:0]            gyro_r,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [CH_W-1:0]               res_channel,
  output logic signed [EST_W-1:0]       res_estimate,
  output logic [GAIN_W-1:0]             res_gain
);

  localparam int F   = FRAC_BITS;
  localparam int XW  = SAMPLE_BITS + F;
  localparam int PW  = 8 + F;
  localparam int DW  = 9 + F;
  localparam int RW  = 10 + F;
  localparam int QW  = F + 1;
  localparam int MW  = (XW + 1 > PW) ? XW + 1 : PW;
  localparam int PRW = MW + QW;
  localparam int CIW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [PW-1:0]  P_ONE  = PW'(1) << F;
  localparam logic [PW-1:0]  P_MAX  = {PW{1'b1}};
  localparam logic [F-1:0]   K_MAX  = {F{1'b1}};
  localparam logic [QW-1:0]  Q_ONE  = QW'(1) << F;
  localparam logic [PRW-1:0] HALF_M = PRW'(1) << (F - 1);
  localparam logic signed [XW:0] HALF_X = (XW + 1)'(1) << (F - 1);

  // per-channel state
  logic signed [XW-1:0] est_mem [CHANNELS];
  logic [PW-1:0]        var_mem [CHANNELS];
  logic [CHANNELS-1:0]  primed;

  // working registers of one item
  logic [CH_W-1:0]      ch_r;
  logic                 bad_r;
  logic signed [XW-1:0] mfx_r;
  logic signed [XW-1:0] x_r;
  logic signed [XW:0]   e_r;
  logic [PW-1:0]        p_r, q_r, r_r;
  logic [DW-1:0]        den;
  logic [RW-1:0]        rem;
  logic [QW-1:0]        quo;
  logic [F-1:0]         k_r;

  // shared shift-add multiplier
  logic [PRW-1:0]       mcand, acc;
  logic [QW-1:0]        mplier;

  logic [CIW-1:0]       in_idx, ch_idx;
  logic                 in_bad, in_accel;
  logic signed [XW-1:0] mfx_in;
  logic [PW:0]          p_sum;
  logic                 rem_ge;
  logic [F-1:0]         k_val;
  logic [MW-1:0]        e_mag;
  logic [PRW-1:0]       acc_rnd;
  logic signed [XW-1:0] mag_x;
  logic signed [XW:0]   x_half;

  assign in_idx   = CIW'(in_channel);
  assign ch_idx   = CIW'(ch_r);
  assign in_bad   = 32'(in_channel) >= CHANNELS;
  assign in_accel = 32'(in_channel) < ACCEL_AXES;
  assign mfx_in   = XW'(in_sample) <<< F;
  assign p_sum    = {1'b0, p_r} + {1'b0, q_r};
  assign rem_ge   = rem >= RW'(den);
  assign k_val    = (den == '0) ? '0 : (quo[F] ? K_MAX : quo[F-1:0]);
  assign e_mag    = e_r[XW] ? MW'(-e_r) : MW'(e_r);
  assign acc_rnd  = (acc + HALF_M) >> F;
  assign mag_x    = XW'(acc_rnd);
  assign x_half   = (XW + 1)'(x_r) + HALF_X;

  assign stat.bad_ch   = bad_r;
  assign stat.res_busy = res_valid && !res_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch_r  <= in_channel;
      bad_r <= in_bad;
      mfx_r <= mfx_in;
      q_r   <= PW'(in_accel ? accel_q : gyro_q) << (F - NOISE_FRAC);
      r_r   <= PW'(in_accel ? accel_r : gyro_r) << (F - NOISE_FRAC);
      if (!in_bad && primed[in_idx]) begin
        x_r <= est_mem[in_idx];
        p_r <= var_mem[in_idx];
      end else begin
        // first sample on a channel loads the measurement
        x_r <= mfx_in;
        p_r <= P_ONE;
      end
    end
    if (cmd.predict) begin
      p_r <= p_sum[PW] ? P_MAX : p_sum[PW-1:0];
      e_r <= (XW + 1)'(mfx_r) - (XW + 1)'(x_r);
    end
    if (cmd.div_init) begin
      den <= DW'(p_r) + DW'(r_r);
      rem <= RW'(p_r);
      quo <= '0;
    end
    if (cmd.div_step) begin
      rem <= rem_ge ? (rem - RW'(den)) << 1 : rem << 1;
      quo <= {quo[QW-2:0], rem_ge};
    end
    if (cmd.gain_set) begin
      k_r    <= k_val;
      mcand  <= PRW'(e_mag);
      mplier <= QW'(k_val);
      acc    <= '0;
    end
    if (cmd.mul_step) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
    if (cmd.x_update) begin
      x_r    <= e_r[XW] ? x_r - mag_x : x_r + mag_x;
      mcand  <= PRW'(p_r);
      mplier <= Q_ONE - QW'(k_r);
      acc    <= '0;
    end
    if (cmd.commit && !bad_r) begin
      est_mem[ch_idx] <= x_r;
      var_mem[ch_idx] <= PW'(acc_rnd);
    end
    if (cmd.commit) begin
      res_channel  <= ch_r;
      res_estimate <= bad_r ? '0 : EST_W'(signed'(x_half[XW:F]));
      res_gain     <= bad_r ? '0 : GAIN_W'(k_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      primed    <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.commit && !bad_r) begin
        primed[ch_idx] <= 1'b1;
      end
      if (cmd.commit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

>>> src/scalar_kalman_six_channel.sv
// channel  | dir | payload                          | handshake
// inp      | in  | channel, sample                  | valid / ready
// res      | out | channel_out, estimate, gain      | valid / ready
// apb      | in  | four 16-bit noise registers      | psel / penable, pready tied high
//
// after the input transfer the item runs through the bit-serial divider and then
// twice through the shared shift-add multiplier before the result is offered
// a new sample is taken in the cycle after the previous one reached the result register
// reset (rst, synchronous) clears the primed flags, the controller and result valid, and restores the noise registers
// a stalled result holds the block in its last step until the result is taken
module scalar_kalman_six_channel import skf_pkg::*; #(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  skf_in_if.sink                inp,
  skf_out_if.source             res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // noise registers, all unsigned Q8.8
  logic [NOISE_W-1:0] accel_q, accel_r, gyro_q, gyro_r;
  reg_idx_t           reg_idx;
  logic               cfg_wr;

  skf_cmd_t  cmd;
  skf_stat_t stat;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  // write lands on the access phase of the transfer
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_q <= ACCEL_Q_RST;
      accel_r <= ACCEL_R_RST;
      gyro_q  <= GYRO_Q_RST;
      gyro_r  <= GYRO_R_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ACCEL_Q: accel_q <= pwdata[NOISE_W-1:0];
        REG_ACCEL_R: accel_r <= pwdata[NOISE_W-1:0];
        REG_GYRO_Q:  gyro_q  <= pwdata[NOISE_W-1:0];
        REG_GYRO_R:  gyro_r  <= pwdata[NOISE_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      REG_ACCEL_Q: prdata = APB_DATA_W'(accel_q);
      REG_ACCEL_R: prdata = APB_DATA_W'(accel_r);
      REG_GYRO_Q:  prdata = APB_DATA_W'(gyro_q);
      REG_GYRO_R:  prdata = APB_DATA_W'(gyro_r);
      default:     prdata = '0;
    endcase
  end

  // sequencer: load, predict, divide, two multiplies, commit
  skf_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (inp.valid),
    .in_ready (inp.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // per-channel state, divider, multiplier and result register
  skf_datapath #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_channel   (inp.channel),
    .in_sample    (inp.sample),
    .accel_q      (accel_q),
    .accel_r      (accel_r),
    .gyro_q       (gyro_q),
    .gyro_r       (gyro_r),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .res_channel  (res.channel_out),
    .res_estimate (res.estimate),
    .res_gain     (res.gain)
  );

endmodule

>>> src/skf_checker.sv
`include "assert_macros.svh"

module skf_checker import skf_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              res_valid,
  input logic              res_ready,
  input logic [CH_W-1:0]   res_channel,
  input logic [EST_W-1:0]  res_estimate,
  input logic [GAIN_W-1:0] res_gain
);

  logic res_bad;
  assign res_bad = 32'(res_channel) >= CHANNELS;

  // one item at a time: no second transfer right after one
  `ASSERT_NEXT(a_one_at_a_time, clk, rst, in_valid && in_ready, !in_ready)
  // unknown channel gives an empty result
  `ASSERT_IMPLIES(a_bad_ch_zero, clk, rst, res_valid && res_bad, res_estimate == '0 && res_gain == '0)
  // nothing comes out right after reset
  `ASSERT_NEXT_ALWAYS(a_reset_quiet, clk, rst, !res_valid)
  // a waiting result stays offered
  `ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid)

endmodule

bind scalar_kalman_six_channel skf_checker #(
  .CHANNELS (CHANNELS)
) u_skf_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (inp.valid),
  .in_ready     (inp.ready),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .res_channel  (res.channel_out),
  .res_estimate (res.estimate),
  .res_gain     (res.gain)
);

>>> tb/kalman_result_checker.sv
`timescale 1ns / 1ps

module kalman_result_checker import skf_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [CH_W-1:0]                in_channel,
  input  logic signed [SAMPLE_BITS_DEF-1:0] in_sample,
  input  logic                           res_valid,
  input  logic                           res_ready,
  input  logic [CH_W-1:0]                res_channel,
  input  logic signed [EST_W-1:0]        res_estimate,
  input  logic [GAIN_W-1:0]              res_gain,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [PADDR_W-1:0]             paddr,
  input  logic [APB_DATA_W-1:0]          pwdata,
  output int                             pending,
  output int                             errors
);

  localparam int FRAC = FRAC_BITS_DEF;
  localparam longint ONE_S = 64'sd1 <<< FRAC;
  localparam longint HALF_S = 64'sd1 <<< (FRAC - 1);
  localparam longint unsigned ONE_U = 64'd1 << FRAC;
  localparam longint unsigned HALF_U = 64'd1 << (FRAC - 1);
  localparam longint unsigned K_MAX = ONE_U - 64'd1;
  localparam longint unsigned P_MAX = (64'd1 << (8 + FRAC)) - 64'd1;

  typedef struct packed {
    logic [CH_W-1:0]   ch;
    logic [EST_W-1:0]  est;
    logic [GAIN_W-1:0] gain;
  } filt_result_t;

  filt_result_t        filtered_expected[$];
  logic [NOISE_W-1:0]  noise_reg [4];
  longint              axis_est [CHANNELS_DEF];
  longint unsigned     axis_var [CHANNELS_DEF];
  logic                axis_primed [CHANNELS_DEF];
  int                  mismatch_count = 0;

  assign errors = mismatch_count;

  // k * mag / 2^F, halves rounded up
  function automatic longint unsigned scale_round(input longint unsigned k,
                                                  input longint unsigned mag);
    return k * (mag >> FRAC) + ((k * (mag & (ONE_U - 64'd1)) + HALF_U) >> FRAC);
  endfunction

  // one filter step on the watched state, returns the result it should produce
  function automatic filt_result_t kalman_update(input logic [CH_W-1:0] ch,
                                                 input logic signed [SAMPLE_BITS_DEF-1:0] smp);
    filt_result_t    r;
    longint          mfx;
    longint          x;
    longint          err;
    longint          rounded;
    longint unsigned q;
    longint unsigned rn;
    longint unsigned p;
    longint unsigned den;
    longint unsigned k;
    r.ch   = ch;
    r.est  = '0;
    r.gain = '0;
    if (ch >= CHANNELS_DEF) return r;
    mfx = longint'(smp) * ONE_S;
    if (ch < ACCEL_AXES) begin
      q  = longint'(noise_reg[REG_ACCEL_Q]);
      rn = longint'(noise_reg[REG_ACCEL_R]);
    end else begin
      q  = longint'(noise_reg[REG_GYRO_Q]);
      rn = longint'(noise_reg[REG_GYRO_R]);
    end
    q  = q << (FRAC - NOISE_FRAC);
    rn = rn << (FRAC - NOISE_FRAC);
    if (!axis_primed[ch]) begin
      axis_est[ch]    = mfx;
      axis_var[ch]    = ONE_U;
      axis_primed[ch] = 1'b1;
    end
    x = axis_est[ch];
    p = axis_var[ch] + q;
    if (p > P_MAX) p = P_MAX;
    den = p + rn;
    if (den == 0) begin
      k = 0;
    end else begin
      k = (p << FRAC) / den;
      if (k > K_MAX) k = K_MAX;
    end
    err = mfx - x;
    if (err >= 0) x = x + longint'(scale_round(k, err));
    else x = x - longint'(scale_round(k, -err));
    p = ((ONE_U - k) * p + HALF_U) >> FRAC;
    axis_est[ch] = x;
    axis_var[ch] = p;
    rounded = (x + HALF_S) >>> FRAC;
    r.est   = rounded[EST_W-1:0];
    r.gain  = k[GAIN_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    filt_result_t want;
    if (rst) begin
      noise_reg[REG_ACCEL_Q] = ACCEL_Q_RST;
      noise_reg[REG_ACCEL_R] = ACCEL_R_RST;
      noise_reg[REG_GYRO_Q]  = GYRO_Q_RST;
      noise_reg[REG_GYRO_R]  = GYRO_R_RST;
      for (int i = 0; i < CHANNELS_DEF; i++) begin
        axis_est[i]    = 0;
        axis_var[i]    = 0;
        axis_primed[i] = 1'b0;
      end
      filtered_expected.delete();
    end else begin
      if (psel && penable && pwrite && pready)
        noise_reg[paddr[PADDR_W-1:2]] = pwdata[NOISE_W-1:0];
      // retire before predicting so a result never meets its own item
      if (res_valid && res_ready) begin
        if (filtered_expected.size() == 0) begin
          $display("%0t: result with nothing expected, channel_out %0d estimate %0d gain %0d",
                   $time, res_channel, res_estimate, res_gain);
          mismatch_count++;
        end else begin
          want = filtered_expected.pop_front();
          if (res_channel !== want.ch) begin
            $display("%0t: channel_out expected %0d, actual %0d", $time, want.ch, res_channel);
            mismatch_count++;
          end
          if (res_estimate !== want.est) begin
            $display("%0t: estimate on channel %0d expected %0d, actual %0d",
                     $time, want.ch, $signed(want.est), res_estimate);
            mismatch_count++;
          end
          if (res_gain !== want.gain) begin
            $display("%0t: gain on channel %0d expected %0d, actual %0d",
                     $time, want.ch, want.gain, res_gain);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready)
        filtered_expected.push_back(kalman_update(in_channel, in_sample));
    end
    pending <= filtered_expected.size();
  end

endmodule

>>> tb/scalar_kalman_six_channel_tb.sv
`timescale 1ns / 1ps

module scalar_kalman_six_channel_tb;
  import skf_pkg::*;

  localparam int ITEM_LATENCY      = 3 * (FRAC_BITS_DEF + 1) + 6;
  localparam int SETTLE_CYCLES     = ITEM_LATENCY + 8;
  localparam int ITEMS_PER_SEGMENT = 85;
  localparam int SEGMENTS          = 6;
  localparam int RECV_HOLD_CYCLES  = 300;
  localparam int DRAIN_LIMIT       = 4000;
  localparam int RUN_LIMIT_NS      = 5_000_000;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_W-1:0]    paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  skf_in_if #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) in_bus ();
  skf_out_if                                 out_bus ();

  int send_idle_pct;
  int recv_idle_pct;
  int recv_hold;     // cycles the result side still has to hold off
  int pending;
  int errors;
  int level [8];     // slow-moving per-axis signal the noisy samples sit on

  scalar_kalman_six_channel dut (
    .clk     (clk),
    .rst     (rst),
    .inp     (in_bus),
    .res     (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  kalman_result_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_bus.valid),
    .in_ready     (in_bus.ready),
    .in_channel   (in_bus.channel),
    .in_sample    (in_bus.sample),
    .res_valid    (out_bus.valid),
    .res_ready    (out_bus.ready),
    .res_channel  (out_bus.channel_out),
    .res_estimate (out_bus.estimate),
    .res_gain     (out_bus.gain),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pending      (pending),
    .errors       (errors)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // hard stop in case the block hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side: random back-pressure, or a long hold-off while recv_hold counts down
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (recv_hold > 0) begin
        out_bus.ready <= 1'b0;
        recv_hold--;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // setup cycle then access cycle; the register takes the value at the end of access
  task automatic apb_write(input reg_idx_t idx, input logic [NOISE_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {{(APB_DATA_W-NOISE_W){1'b0}}, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // drop valid and wait for every outstanding result to be taken
  task automatic wait_drained();
    int waited;
    waited = 0;
    in_bus.valid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending != 0 && waited < DRAIN_LIMIT);
    if (pending != 0) begin
      $display("%0t: results still outstanding after %0d cycles", $time, waited);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  endtask

  // noise registers only change with the block empty
  task automatic configure(input logic [NOISE_W-1:0] aq, input logic [NOISE_W-1:0] ar,
                           input logic [NOISE_W-1:0] gq, input logic [NOISE_W-1:0] gr);
    wait_drained();
    apb_write(REG_ACCEL_Q, aq);
    apb_write(REG_ACCEL_R, ar);
    apb_write(REG_GYRO_Q, gq);
    apb_write(REG_GYRO_R, gr);
  endtask

  // offers one sample; returns at the edge of its transfer with valid still up,
  // so back-to-back items keep valid high without a glitch
  task automatic send_item(input logic [CH_W-1:0] ch,
                           input logic signed [SAMPLE_BITS_DEF-1:0] smp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.channel <= ch;
    in_bus.sample  <= smp;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // mostly real axes, now and then the two unused channel codes
  function automatic logic [CH_W-1:0] pick_channel();
    if ($urandom_range(9) == 0) return CH_W'(CHANNELS_DEF + $urandom_range(1));
    return CH_W'($urandom_range(CHANNELS_DEF - 1));
  endfunction

  // extremes, full-range noise, or small jitter around a level that jumps now and then
  function automatic logic signed [SAMPLE_BITS_DEF-1:0] pick_sample(input int ch);
    int v;
    case ($urandom_range(9))
      0: v = $urandom_range(1) ? 32767 : -32768;
      1, 2, 3: v = int'($urandom_range(65535)) - 32768;
      default: begin
        if ($urandom_range(19) == 0) level[ch] = int'($urandom_range(65535)) - 32768;
        v = level[ch] + int'($urandom_range(64)) - 32;
      end
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[SAMPLE_BITS_DEF-1:0];
  endfunction

  // zero, full scale, anything, or a typical small value
  function automatic logic [NOISE_W-1:0] pick_noise();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2, 3: return NOISE_W'($urandom_range(65535));
      default: return NOISE_W'($urandom_range(2048, 1));
    endcase
  endfunction

  initial begin
    logic [CH_W-1:0] ch;
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_bus.valid   = 1'b0;
    in_bus.channel = '0;
    in_bus.sample  = '0;
    send_idle_pct = 35;
    recv_idle_pct = 50;
    recv_hold     = 0;
    foreach (level[i]) level[i] = 0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // first sample on each axis primes it; reset noise values
    send_item(0, 16'sd0);
    send_item(1, 16'sd32767);
    send_item(2, -16'sd32768);
    send_item(3, 16'sd1);
    send_item(4, 16'sd32767);
    send_item(5, -16'sd32768);
    // unused channel codes: echoed, no state change
    send_item(6, 16'sd100);
    send_item(7, -16'sd1);
    // full-scale swings on primed axes
    send_item(0, 16'sd32767);
    send_item(0, -16'sd32768);
    send_item(5, 16'sd32767);
    send_item(1, -16'sd32768);

    // accel: no noise at all, so the gain pins just below one and the variance
    // collapses until p + r is zero; gyro: maximum noise drives p into saturation
    configure(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
    send_item(1, 16'sd5);
    send_item(1, -16'sd5);
    send_item(1, 16'sd1000);
    send_item(1, 16'sd0);
    send_item(4, 16'sd32767);
    send_item(4, -16'sd32768);
    send_item(4, 16'sd0);
    send_item(3, 16'sd12);
    send_item(7, 16'sd32767);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: configure(ACCEL_Q_RST, ACCEL_R_RST, GYRO_Q_RST, GYRO_R_RST);
        1: configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: configure(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        default: configure(pick_noise(), pick_noise(), pick_noise(), pick_noise());
      endcase
      // swap idling sides a third of the way in, then run the last two segments with no gaps at all
      if (seg == 2) begin
        send_idle_pct = 50;
        recv_idle_pct = 35;
      end else if (seg == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // long result stall while samples keep coming, so the input backs up
      if (seg == 1) recv_hold = RECV_HOLD_CYCLES;
      for (int n = 0; n < ITEMS_PER_SEGMENT; n++) begin
        // sender pause with everything drained, config unchanged
        if (seg == 3 && n == ITEMS_PER_SEGMENT / 2) wait_drained();
        ch = pick_channel();
        send_item(ch, pick_sample(ch));
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/skf_pkg.sv
src/skf_stream_if.sv
src/skf_ctrl.sv
src/skf_datapath.sv
src/scalar_kalman_six_channel.sv
src/skf_checker.sv
tb/kalman_result_checker.sv
tb/scalar_kalman_six_channel_tb.sv
